[src/assert_macros.svh]
// Assertion macros shared by the segmenter RTL.
// Include-guarded; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define PPS_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define PPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pps_pkg.sv]
// Shared types and constants for the projection profile segmenter.
// No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

    localparam int unsigned GAP_W       = 8;
    localparam int unsigned PIXEL_W     = 16;
    localparam int unsigned SEG_W       = 12;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam int unsigned MAX_SCANS_DEFAULT   = 4096;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [GAP_W-1:0]   GAP_THRESHOLD_RESET = 8'd5;
    localparam logic [PIXEL_W-1:0] INK_VALUE_RESET     = 16'd0;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INK_VALUE     = 1'b1;

    // One finished scan line, handed from front to back
    typedef struct packed {
        logic ink;   // line held at least one ink pixel
        logic last;  // line closes the image
    } line_event_t;

    // One emitted segment
    typedef struct packed {
        logic [SEG_W-1:0] seg_start;
        logic [SEG_W-1:0] seg_end;
        logic [SEG_W-1:0] seg_number;
        logic             image_done;
    } seg_result_t;

endpackage

[src/projection_profile_segmenter_unit.sv]
// A line-ending pixel's result passes a queue entry, then the result register.
// Throughput: one pixel beat per cycle; the front stalls only when the line-event queue fills
// while the result register is held by the consumer.
// Reset (rst_n, asynchronous, active low): segment state and counters clear,
// gap_threshold returns to 5 and ink_value to 0.
// Top level: configuration registers, front end, line-event queue and back end.
// Depends on pps_pkg, pps_front, pps_fifo and pps_back.
`timescale 1ns / 1ps

module projection_profile_segmenter_unit #(
    parameter int unsigned MAX_SCANS   = pps_pkg::MAX_SCANS_DEFAULT,
    parameter int unsigned QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  logic [pps_pkg::PIXEL_W-1:0]     pixel_value,
    input  logic                            end_of_scan,
    input  logic                            end_of_image,
    output logic                            seg_valid,
    input  logic                            seg_ready,
    output logic [pps_pkg::SEG_W-1:0]       seg_start,
    output logic [pps_pkg::SEG_W-1:0]       seg_end,
    output logic [pps_pkg::SEG_W-1:0]       seg_number,
    output logic                            image_done
);
    import pps_pkg::*;

    logic [GAP_W-1:0]   gap_threshold_reg, gap_threshold_next;
    logic [PIXEL_W-1:0] ink_value_reg,     ink_value_next;

    logic               ev_push;
    line_event_t        ev_push_data;
    logic               q_full;
    logic               ev_pop;
    line_event_t        ev_pop_data;
    logic               q_not_empty;
    seg_result_t        res;

    // Configuration write decode
    always_comb
    begin
        gap_threshold_next = gap_threshold_reg;
        ink_value_next     = ink_value_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAP_THRESHOLD: gap_threshold_next = cfg_wdata[GAP_W-1:0];
                CFG_INK_VALUE:     ink_value_next     = cfg_wdata[PIXEL_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_threshold_reg <= GAP_THRESHOLD_RESET;
            ink_value_reg     <= INK_VALUE_RESET;
        end
        else
        begin
            gap_threshold_reg <= gap_threshold_next;
            ink_value_reg     <= ink_value_next;
        end
    end

    pps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_value  (pixel_value),
        .end_of_scan  (end_of_scan),
        .end_of_image (end_of_image),
        .ink_value    (ink_value_reg),
        .q_full       (q_full),
        .ev_push      (ev_push),
        .ev_data      (ev_push_data)
    );

    pps_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ev_push),
        .push_data (ev_push_data),
        .full      (q_full),
        .pop       (ev_pop),
        .pop_data  (ev_pop_data),
        .not_empty (q_not_empty)
    );

    pps_back #(
        .MAX_SCANS (MAX_SCANS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .gap_threshold (gap_threshold_reg),
        .ev_valid      (q_not_empty),
        .ev_data       (ev_pop_data),
        .ev_pop        (ev_pop),
        .res_valid     (seg_valid),
        .res_ready     (seg_ready),
        .res           (res)
    );

    assign seg_start  = res.seg_start;
    assign seg_end    = res.seg_end;
    assign seg_number = res.seg_number;
    assign image_done = res.image_done;

endmodule

[src/pps_front.sv]
// Front end: accepts pixel beats, detects ink, emits one event per scan line.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pixel_valid,
    output logic                         pixel_ready,
    input  logic [pps_pkg::PIXEL_W-1:0]  pixel_value,
    input  logic                         end_of_scan,
    input  logic                         end_of_image,
    input  logic [pps_pkg::PIXEL_W-1:0]  ink_value,
    input  logic                         q_full,
    output logic                         ev_push,
    output pps_pkg::line_event_t         ev_data
);
    import pps_pkg::*;

    logic scan_has_ink_reg;
    logic scan_has_ink_next;
    logic accept;
    logic line_ink;
    logic line_end;

    // Take a beat whenever the queue has room
    assign pixel_ready = !q_full;
    assign accept      = pixel_valid && pixel_ready;

    // Ink flag for the line so far, including this pixel
    assign line_ink = scan_has_ink_reg || (pixel_value == ink_value);
    assign line_end = end_of_scan || end_of_image;

    assign ev_push      = accept && line_end;
    assign ev_data.ink  = line_ink;
    assign ev_data.last = end_of_image;

    always_comb
    begin
        scan_has_ink_next = scan_has_ink_reg;
        if (accept)
        begin
            scan_has_ink_next = line_end ? 1'b0 : line_ink;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_has_ink_reg <= 1'b0;
        end
        else
        begin
            scan_has_ink_reg <= scan_has_ink_next;
        end
    end

endmodule

[src/pps_fifo.sv]
// Short queue of scan-line events between front and back.
// Depends on pps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pps_fifo #(
    parameter int unsigned DEPTH = pps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pps_pkg::line_event_t  push_data,
    output logic                  full,
    input  logic                  pop,
    output pps_pkg::line_event_t  pop_data,
    output logic                  not_empty
);
    import pps_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    line_event_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PPS_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full), "push into full queue")
    `PPS_ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && !not_empty), "pop from empty queue")

endmodule

[src/pps_back.sv]
// Back end: tracks segments over scan-line events and holds the result register.
// Depends on pps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pps_back #(
    parameter int unsigned MAX_SCANS = pps_pkg::MAX_SCANS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pps_pkg::GAP_W-1:0]   gap_threshold,
    input  logic                        ev_valid,
    input  pps_pkg::line_event_t        ev_data,
    output logic                        ev_pop,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pps_pkg::seg_result_t        res
);
    import pps_pkg::*;

    localparam int unsigned SCAN_W = $clog2(MAX_SCANS);

    // Scan index to output field width
    function automatic logic [SEG_W-1:0] to_seg(input logic [SCAN_W-1:0] v);
        logic [SCAN_W+SEG_W-1:0] tmp;
        tmp = {{SEG_W{1'b0}}, v};
        return tmp[SEG_W-1:0];
    endfunction

    logic [SCAN_W-1:0] scan_index_reg,    scan_index_next;
    logic              in_segment_reg,    in_segment_next;
    logic [SCAN_W-1:0] open_start_reg,    open_start_next;
    logic [GAP_W-1:0]  blank_run_reg,     blank_run_next;
    logic [SEG_W-1:0]  segment_count_reg, segment_count_next;
    logic              res_valid_reg,     res_valid_next;
    seg_result_t       res_reg,           res_next;

    logic              emit;
    logic [GAP_W-1:0]  blank_inc;
    logic [SCAN_W-1:0] run_m;
    logic [SCAN_W:0]   end_wrapped;
    logic [SCAN_W-1:0] gap_end;
    logic [SCAN_W-1:0] run_mod_tbl [2**GAP_W];

    // Blank run reduced modulo the scan count (constant table)
    for (genvar g = 0; g < 2**GAP_W; g++)
    begin : g_run_mod
        assign run_mod_tbl[g] = SCAN_W'(g % MAX_SCANS);
    end

    // Pop when the result register is free or drains this cycle
    assign ev_pop    = ev_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Last inked line of a gap-closed segment
    assign blank_inc   = blank_run_reg + 1'b1;
    assign run_m       = run_mod_tbl[blank_inc];
    assign end_wrapped = {1'b0, scan_index_reg} + (SCAN_W + 1)'(MAX_SCANS) - {1'b0, run_m};
    assign gap_end     = (scan_index_reg >= run_m) ? (scan_index_reg - run_m)
                                                   : end_wrapped[SCAN_W-1:0];

    // Segment tracking for one popped scan line
    always_comb
    begin
        scan_index_next    = scan_index_reg;
        in_segment_next    = in_segment_reg;
        open_start_next    = open_start_reg;
        blank_run_next     = blank_run_reg;
        segment_count_next = segment_count_reg;
        res_next           = res_reg;
        emit               = 1'b0;

        if (ev_pop)
        begin
            if (ev_data.ink)
            begin
                if (!in_segment_reg)
                begin
                    in_segment_next = 1'b1;
                    open_start_next = scan_index_reg;
                end
                blank_run_next = '0;
            end
            else if (in_segment_reg)
            begin
                if (blank_inc >= gap_threshold)
                begin
                    // gap reached: close the segment
                    emit                = 1'b1;
                    res_next.seg_start  = to_seg(open_start_reg);
                    res_next.seg_end    = to_seg(gap_end);
                    res_next.image_done = 1'b0;
                    in_segment_next     = 1'b0;
                    blank_run_next      = '0;
                end
                else
                begin
                    blank_run_next = blank_inc;
                end
            end

            if (ev_data.last)
            begin
                // flush an open segment and rewind for the next image
                if (in_segment_next)
                begin
                    emit                = 1'b1;
                    res_next.seg_start  = to_seg(open_start_next);
                    res_next.seg_end    = to_seg(scan_index_reg);
                    res_next.image_done = 1'b1;
                end
                scan_index_next = '0;
                in_segment_next = 1'b0;
                open_start_next = '0;
                blank_run_next  = '0;
            end
            else
            begin
                scan_index_next = (scan_index_reg == SCAN_W'(MAX_SCANS - 1))
                                  ? '0 : scan_index_reg + 1'b1;
            end

            if (emit)
            begin
                segment_count_next  = segment_count_reg + 1'b1;
                res_next.seg_number = segment_count_reg + 1'b1;
            end
        end
    end

    // Result register valid flag
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (ev_pop)
        begin
            res_valid_next = emit;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_index_reg    <= '0;
            in_segment_reg    <= 1'b0;
            open_start_reg    <= '0;
            blank_run_reg     <= '0;
            segment_count_reg <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            scan_index_reg    <= scan_index_next;
            in_segment_reg    <= in_segment_next;
            open_start_reg    <= open_start_next;
            blank_run_reg     <= blank_run_next;
            segment_count_reg <= segment_count_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    `PPS_ASSERT_ALWAYS(a_blank_in_segment, clk, rst_n,
        (blank_run_reg == '0) || in_segment_reg, "blank run outside a segment")
    `PPS_ASSERT_NEXT(a_image_rewind, clk, rst_n, ev_pop && ev_data.last,
        (scan_index_reg == '0) && !in_segment_reg, "no rewind after image end")
    `PPS_ASSERT_ALWAYS(a_number_tracks_count, clk, rst_n,
        !res_valid_reg || (res_reg.seg_number == segment_count_reg),
        "result number differs from segment count")

endmodule
